// File: hw/rtl/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg: shared types and constants of the command frame encoder
// Command codes, value limits, frame constants and the frame record that
// passes from the command stage to the byte serializer.
// ----------------------------------------------------------------------------
package rcf_pkg;

    // command codes
    typedef enum logic [3:0] {
        CMD_RESET        = 4'd0,
        CMD_LIGHT_TOGGLE = 4'd1,
        CMD_TRIM_UP      = 4'd2,
        CMD_TRIM_DOWN    = 4'd3,
        CMD_FB_INC       = 4'd4,
        CMD_FB_DEC       = 4'd5,
        CMD_FB_SET       = 4'd6,
        CMD_LR_INC       = 4'd7,
        CMD_LR_DEC       = 4'd8,
        CMD_LR_SET       = 4'd9,
        CMD_LR_CENTER    = 4'd10,
        CMD_SPEED_INC    = 4'd11,
        CMD_SPEED_DEC    = 4'd12,
        CMD_SPEED_SET    = 4'd13,
        CMD_SEND         = 4'd14,
        CMD_NOP          = 4'd15
    } cmd_mode_t;

    // value limits
    localparam logic [3:0]        AXIS_MAX    = 4'd14;
    localparam logic [3:0]        AXIS_MIN    = 4'd1;
    localparam logic [3:0]        AXIS_HOME   = 4'd8;
    localparam logic [6:0]        SPEED_MAX   = 7'd80;
    localparam logic signed [3:0] TRIM_LIMIT  = 4'sd6;

    // frame constants
    localparam logic [7:0] HDR_A      = 8'h55;
    localparam logic [7:0] HDR_B      = 8'hAA;
    localparam logic [7:0] FIXED_BYTE = 8'h40;
    localparam logic [7:0] NO_SPEED   = 8'h80;

    localparam int          FRAME_LEN  = 6;
    localparam logic [2:0]  LAST_IDX   = 3'(FRAME_LEN - 1);

    // byte positions within the frame
    typedef enum logic [2:0] {
        POS_HDR_A = 3'd0,
        POS_HDR_B = 3'd1,
        POS_SPEED = 3'd2,
        POS_AXES  = 3'd3,
        POS_FIXED = 3'd4,
        POS_TAIL  = 3'd5
    } frame_pos_t;

    // variable bytes of one frame, snapshot at the send command
    typedef struct packed {
        logic [7:0] speed_byte;
        logic [7:0] axes_byte;
        logic [7:0] tail_byte;
    } frame_rec_t;

endpackage

// File: hw/rtl/rcf_ifs.sv
// ----------------------------------------------------------------------------
// rcf_ifs: request channels of the command frame encoder
// Command channel (mode, value) and frame byte channel (frame_byte,
// last_byte), both valid/ready.
// ----------------------------------------------------------------------------
interface rcf_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] mode;
    logic [7:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface rcf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/rcf_front.sv
// ----------------------------------------------------------------------------
// rcf_front: command stage
// Applies one command per cycle, while cmd_fire is high, to the control values and, on send,
// builds the frame record (speed byte, axes byte, light and checksum byte).
// ----------------------------------------------------------------------------
module rcf_front
    import rcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_fire,
    input  logic [3:0] cmd_mode,
    input  logic [7:0] cmd_value,
    output logic       rec_push,
    output frame_rec_t rec_data
);

    logic [6:0]        speed_reg, speed_next;
    logic [3:0]        pitch_reg, pitch_next;
    logic [3:0]        roll_reg,  roll_next;
    logic signed [3:0] trim_reg,  trim_next;
    logic              light_reg, light_next;

    cmd_mode_t         mode;
    logic [7:0]        lr_base;
    logic signed [9:0] lr_sum;
    logic [7:0]        speed_byte;
    logic [7:0]        axes_byte;
    logic [7:0]        tail_hi;
    logic [7:0]        csum;

    assign mode = cmd_mode_t'(cmd_mode);

    // left/right set: trim plus base in full precision, clamped
    assign lr_base = (mode == CMD_LR_CENTER) ? {4'd0, AXIS_HOME} : cmd_value;
    assign lr_sum  = 10'(trim_reg) + $signed({2'b00, lr_base});

    // next control values
    always_comb
    begin
        speed_next = speed_reg;
        pitch_next = pitch_reg;
        roll_next  = roll_reg;
        trim_next  = trim_reg;
        light_next = light_reg;
        unique case (mode)
            CMD_RESET:
            begin
                speed_next = 7'd0;
                pitch_next = AXIS_HOME;
                roll_next  = AXIS_HOME;
                trim_next  = 4'sd0;
                light_next = 1'b0;
            end
            CMD_LIGHT_TOGGLE: light_next = ~light_reg;
            CMD_TRIM_UP:
                if (trim_reg < TRIM_LIMIT) trim_next = trim_reg + 4'sd1;
            CMD_TRIM_DOWN:
                if (trim_reg > -TRIM_LIMIT) trim_next = trim_reg - 4'sd1;
            CMD_FB_INC:
                if (pitch_reg < AXIS_MAX) pitch_next = pitch_reg + 4'd1;
            CMD_FB_DEC:
                if (pitch_reg > AXIS_MIN) pitch_next = pitch_reg - 4'd1;
            CMD_FB_SET:
                pitch_next = (cmd_value >= 8'(AXIS_MIN) && cmd_value <= 8'(AXIS_MAX))
                           ? cmd_value[3:0] : AXIS_HOME;
            CMD_LR_INC:
                if (roll_reg < AXIS_MAX) roll_next = roll_reg + 4'd1;
            CMD_LR_DEC:
                if (roll_reg > AXIS_MIN) roll_next = roll_reg - 4'd1;
            CMD_LR_SET, CMD_LR_CENTER:
            begin
                if (lr_sum <= 10'sd1)
                    roll_next = AXIS_MIN;
                else if (lr_sum >= 10'sd14)
                    roll_next = AXIS_MAX;
                else
                    roll_next = lr_sum[3:0];
            end
            CMD_SPEED_INC:
                if (speed_reg < SPEED_MAX) speed_next = speed_reg + 7'd1;
            CMD_SPEED_DEC:
                speed_next = (speed_reg > 7'd1) ? speed_reg - 7'd1 : 7'd0;
            CMD_SPEED_SET:
                speed_next = (cmd_value >= 8'd1 && cmd_value <= 8'(SPEED_MAX))
                           ? cmd_value[6:0] : 7'd0;
            CMD_SEND, CMD_NOP: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 7'd0;
            pitch_reg <= AXIS_HOME;
            roll_reg  <= AXIS_HOME;
            trim_reg  <= 4'sd0;
            light_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            speed_reg <= speed_next;
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
            trim_reg  <= trim_next;
            light_reg <= light_next;
        end
    end

    // frame record from the current values
    assign speed_byte = (speed_reg >= 7'd1 && speed_reg <= SPEED_MAX)
                      ? {1'b0, speed_reg} : NO_SPEED;
    assign axes_byte  = {roll_reg, pitch_reg};
    assign tail_hi    = {light_reg, 7'd0};
    assign csum       = speed_byte + axes_byte + FIXED_BYTE + tail_hi;

    assign rec_push            = cmd_fire && (mode == CMD_SEND);
    assign rec_data.speed_byte = speed_byte;
    assign rec_data.axes_byte  = axes_byte;
    assign rec_data.tail_byte  = {light_reg, 3'd0, csum[7:4]};

endmodule

// File: hw/rtl/rcf_queue.sv
// ----------------------------------------------------------------------------
// rcf_queue: frame record queue
// Short register FIFO between the command stage and the serializer.
// ----------------------------------------------------------------------------
module rcf_queue
    import rcf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_data,
    output logic       not_full,
    input  logic       pop,
    output logic       not_empty,
    output frame_rec_t head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_rec_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: hw/rtl/rcf_back.sv
// ----------------------------------------------------------------------------
// rcf_back: frame serializer
// Takes one frame record at a time and sends its six bytes in order.
// ----------------------------------------------------------------------------
module rcf_back
    import rcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rec_avail,
    input  frame_rec_t rec_data,
    output logic       rec_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    frame_rec_t rec_reg;
    logic [2:0] idx_reg;
    logic       busy_reg;
    logic       out_fire;
    logic       load;

    assign out_fire = busy_reg && out_ready;
    // load when idle, or when the last byte leaves this cycle
    assign load     = rec_avail && (!busy_reg || (out_fire && idx_reg == LAST_IDX));
    assign rec_pop  = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 3'd0;
        end
        else if (out_fire)
        begin
            if (idx_reg == LAST_IDX)
                busy_reg <= 1'b0;
            idx_reg <= (idx_reg == LAST_IDX) ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= rec_data;
    end

    // byte select
    always_comb
    begin
        unique case (frame_pos_t'(idx_reg))
            POS_HDR_A: out_byte = HDR_A;
            POS_HDR_B: out_byte = HDR_B;
            POS_SPEED: out_byte = rec_reg.speed_byte;
            POS_AXES:  out_byte = rec_reg.axes_byte;
            POS_FIXED: out_byte = FIXED_BYTE;
            POS_TAIL:  out_byte = rec_reg.tail_byte;
            default:   out_byte = HDR_A;
        endcase
    end

    assign out_valid = busy_reg;
    assign out_last  = (idx_reg == LAST_IDX);

endmodule

// File: hw/rtl/rc_command_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// rc_command_frame_encoder_unit: remote-control command frame encoder
// Keeps speed, forward/back, left/right, trim and light values under
// commands and emits a six-byte frame for each send command.
// ----------------------------------------------------------------------------
// Timing: a command's new values are registered on acceptance; a send's frame
//   record goes through the frame queue into the serializer before its first byte shows.
// Throughput: one command per cycle while the frame queue has room; frames
//   leave one byte per cycle while the receiver is ready, back to back from the serializer.
// Reset: rst_n low clears values to speed 0, axes 8, trim 0, light off and
//   empties the frame queue.
module rc_command_frame_encoder_unit
    import rcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    rcf_cmd_if.sink      cmd,
    rcf_byte_if.source   frame
);

    logic       cmd_fire;
    logic       rec_push;
    frame_rec_t push_rec;
    logic       q_not_full;
    logic       q_not_empty;
    logic       rec_pop;
    frame_rec_t head_rec;

    assign cmd.ready = q_not_full;
    assign cmd_fire  = cmd.valid && q_not_full;

    rcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_fire  (cmd_fire),
        .cmd_mode  (cmd.mode),
        .cmd_value (cmd.value),
        .rec_push  (rec_push),
        .rec_data  (push_rec)
    );

    rcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (push_rec),
        .not_full  (q_not_full),
        .pop       (rec_pop),
        .not_empty (q_not_empty),
        .head_data (head_rec)
    );

    rcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_avail (q_not_empty),
        .rec_data  (head_rec),
        .rec_pop   (rec_pop),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .out_byte  (frame.frame_byte),
        .out_last  (frame.last_byte)
    );

endmodule

// File: hw/rtl/rcf_checker.sv
// ----------------------------------------------------------------------------
// rcf_checker: port-level checks of the command frame encoder
// Watches the frame byte channel for reset, hold and frame structure.
// ----------------------------------------------------------------------------
module rcf_checker
    import rcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       frame_valid,
    input  logic       frame_ready,
    input  logic [7:0] frame_byte,
    input  logic       last_byte
);

    // nothing offered while in reset
    assert property (@(posedge clk) !rst_n |-> !frame_valid)
        else $error("frame request offered during reset");

    // stalled request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame_byte)
                                         && $stable(last_byte))
        else $error("stalled frame request changed");

    // a frame that follows a finished frame opens with the first header byte
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && last_byte |=> !frame_valid || frame_byte == HDR_A)
        else $error("frame does not start with header");

    // closing byte carries only the light bit and the upper checksum nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && last_byte |-> frame_byte[6:4] == 3'b000)
        else $error("closing byte has stray bits");

endmodule

bind rc_command_frame_encoder_unit rcf_checker u_rcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_byte  (frame.frame_byte),
    .last_byte   (frame.last_byte)
);
